[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and cut by rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SSDR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ssdr_pkg.sv]
// ----------------------------------------------------------------------------
// ssdr_pkg
// shared types and constants of the ssd nearest neighbour ranker
// ----------------------------------------------------------------------------
package ssdr_pkg;

    localparam int DIST_W     = 44;
    localparam int IDX_W      = 6;
    localparam int VLEN_W     = 13;
    localparam int ECNT_W     = 7;
    localparam int CFG_W      = 13;
    localparam int CFG_ADDR_W = 1;

    localparam int DEF_MAX_DIM      = 4096;
    localparam int DEF_MAX_ENTRIES  = 64;
    localparam int DEF_ELEMENT_BITS = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [VLEN_W-1:0] VLEN_RESET = 13'd1024;
    localparam logic [ECNT_W-1:0] ECNT_RESET = 7'd64;

    localparam logic [CFG_ADDR_W-1:0] REG_VECTOR_LENGTH = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ENTRY_COUNT   = 1'd1;

    typedef enum logic {
        OP_QUERY = 1'b0,
        OP_REF   = 1'b1
    } opcode_t;

    // finished entry handed to the ranking cells
    typedef struct packed {
        logic              valid;
        logic              run_end;
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] dist_val;
    } ssdr_ins_t;

    // ranking status back to the accumulator
    typedef struct packed {
        logic emitting;
        logic done;
    } ssdr_status_t;

endpackage

[rtl/core/ssdr_front.sv]
// ----------------------------------------------------------------------------
// ssdr_front
// input acceptance, opcode decode and a short item queue
// ----------------------------------------------------------------------------
module ssdr_front
    import ssdr_pkg::*;
#(
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic signed [ELEMENT_BITS-1:0] element,
    output logic                           q_valid,
    output opcode_t                        q_opcode,
    output logic signed [ELEMENT_BITS-1:0] q_element,
    input  logic                           q_pop
);

    localparam int QDEPTH = 4;
    localparam int PW     = $clog2(QDEPTH);
    localparam int CW     = $clog2(QDEPTH + 1);

    opcode_t                        op_mem [QDEPTH];
    logic signed [ELEMENT_BITS-1:0] el_mem [QDEPTH];
    logic [PW-1:0]                  wr_ptr_reg;
    logic [PW-1:0]                  rd_ptr_reg;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;
    logic                           push;

    assign in_ready  = (count_reg != CW'(QDEPTH));
    assign push      = in_valid && in_ready;
    assign q_valid   = (count_reg != '0);
    assign q_opcode  = op_mem[rd_ptr_reg];
    assign q_element = el_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem[wr_ptr_reg] <= opcode_t'(opcode);
            el_mem[wr_ptr_reg] <= element;
        end
    end

endmodule

[rtl/core/ssdr_accum.sv]
// ----------------------------------------------------------------------------
// ssdr_accum
// query store, squared difference pipeline and per-entry accumulation
// ----------------------------------------------------------------------------
module ssdr_accum
    import ssdr_pkg::*;
#(
    parameter int MAX_DIM      = DEF_MAX_DIM,
    parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_ADDR_W-1:0]          cfg_addr,
    input  logic [CFG_W-1:0]               cfg_wdata,
    input  logic                           q_valid,
    input  opcode_t                        q_opcode,
    input  logic signed [ELEMENT_BITS-1:0] q_element,
    output logic                           q_pop,
    input  ssdr_status_t                   status,
    output ssdr_ins_t                      ins,
    output logic                           busy
);

    localparam int AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int LW  = ((AW + 1) > VLEN_W) ? (AW + 1) : VLEN_W;
    localparam int DW1 = ELEMENT_BITS + 1;
    localparam int SQW = 2 * DW1;
    localparam int MW  = ((SQW > DIST_W) ? SQW : DIST_W) + 1;

    logic [VLEN_W-1:0]              vlen_reg;
    logic [ECNT_W-1:0]              ecnt_reg;
    logic [LW-1:0]                  len_eff;
    logic [ECNT_W-1:0]              cnt_eff;

    logic signed [ELEMENT_BITS-1:0] qmem [MAX_DIM];
    logic signed [ELEMENT_BITS-1:0] qrd_reg;

    logic [AW-1:0]                  qpos_reg;
    logic [AW-1:0]                  epos_reg;
    logic [IDX_W-1:0]               ec_reg;
    logic                           busy_reg;

    logic                           pop_q;
    logic                           pop_r;
    logic [LW-1:0]                  qpos_inc;
    logic [LW-1:0]                  epos_inc;
    logic                           vec_end;
    logic [IDX_W-1:0]               ec_clamp;
    logic [ECNT_W-1:0]              ec_n;
    logic                           run_end;

    // stage b: query word read, element held
    logic                           b_valid_reg;
    logic                           b_end_reg;
    logic                           b_run_end_reg;
    logic [IDX_W-1:0]               b_index_reg;
    logic signed [ELEMENT_BITS-1:0] b_elem_reg;
    logic signed [DW1-1:0]          diff;
    logic [DW1-1:0]                 mag;

    // stage c: square held
    logic                           c_valid_reg;
    logic                           c_end_reg;
    logic                           c_run_end_reg;
    logic [IDX_W-1:0]               c_index_reg;
    logic [SQW-1:0]                 c_sq_reg;
    logic [MW-1:0]                  sq_ext;
    logic [DIST_W-1:0]              sq_clip;
    logic [DIST_W:0]                sum_wide;
    logic [DIST_W-1:0]              sum_sat;
    logic [DIST_W-1:0]              sum_reg;

    logic                           ins_valid_reg;
    logic                           ins_run_end_reg;
    logic [IDX_W-1:0]               ins_index_reg;
    logic [DIST_W-1:0]              ins_dist_reg;

    assign busy  = busy_reg;
    assign ins   = '{valid: ins_valid_reg, run_end: ins_run_end_reg,
                     index: ins_index_reg, dist_val: ins_dist_reg};
    assign q_pop = q_valid && !busy_reg;
    assign pop_q = q_pop && (q_opcode == OP_QUERY);
    assign pop_r = q_pop && (q_opcode == OP_REF);

    // register limits out of range
    always_comb
    begin
        if (vlen_reg == '0)
        begin
            len_eff = LW'(1);
        end
        else if (LW'(vlen_reg) > LW'(MAX_DIM))
        begin
            len_eff = LW'(MAX_DIM);
        end
        else
        begin
            len_eff = LW'(vlen_reg);
        end

        if (ecnt_reg == '0)
        begin
            cnt_eff = ECNT_W'(1);
        end
        else if (ecnt_reg > ECNT_W'(MAX_ENTRIES))
        begin
            cnt_eff = ECNT_W'(MAX_ENTRIES);
        end
        else
        begin
            cnt_eff = ecnt_reg;
        end
    end

    assign qpos_inc = LW'(qpos_reg) + LW'(1);
    assign epos_inc = LW'(epos_reg) + LW'(1);
    assign vec_end  = (epos_inc >= len_eff);
    assign ec_clamp = (ec_reg > IDX_W'(MAX_ENTRIES - 1)) ? IDX_W'(MAX_ENTRIES - 1) : ec_reg;
    assign ec_n     = {1'b0, ec_clamp} + ECNT_W'(1);
    assign run_end  = vec_end && !(ec_n < cnt_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlen_reg <= VLEN_RESET;
            ecnt_reg <= ECNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_VECTOR_LENGTH: vlen_reg <= cfg_wdata[VLEN_W-1:0];
                REG_ENTRY_COUNT:   ecnt_reg <= cfg_wdata[ECNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // stage a: positions, entry counter, run lock
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qpos_reg      <= '0;
            epos_reg      <= '0;
            ec_reg        <= '0;
            busy_reg      <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            sum_reg       <= '0;
            ins_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_q)
            begin
                qpos_reg <= (qpos_inc >= len_eff) ? '0 : qpos_inc[AW-1:0];
            end
            if (pop_r)
            begin
                epos_reg <= vec_end ? '0 : epos_inc[AW-1:0];
                if (vec_end)
                begin
                    ec_reg <= run_end ? '0 : ec_n[IDX_W-1:0];
                end
            end
            if (pop_r && run_end)
            begin
                busy_reg <= 1'b1;
            end
            else if (status.done)
            begin
                busy_reg <= 1'b0;
            end

            b_valid_reg   <= pop_r;
            c_valid_reg   <= b_valid_reg;
            ins_valid_reg <= c_valid_reg && c_end_reg;
            if (c_valid_reg)
            begin
                sum_reg <= c_end_reg ? '0 : sum_sat;
            end
        end
    end

    // query store, read data registered
    always_ff @(posedge clk)
    begin
        if (pop_q)
        begin
            qmem[qpos_reg] <= q_element;
        end
        if (pop_r)
        begin
            qrd_reg <= qmem[epos_reg];
        end
    end

    assign diff = {b_elem_reg[ELEMENT_BITS-1], b_elem_reg} - {qrd_reg[ELEMENT_BITS-1], qrd_reg};
    assign mag  = diff[DW1-1] ? DW1'(-diff) : DW1'(diff);

    // saturating accumulate
    assign sq_ext   = MW'(c_sq_reg);
    assign sq_clip  = (sq_ext > MW'(DIST_MAX)) ? DIST_MAX : sq_ext[DIST_W-1:0];
    assign sum_wide = {1'b0, sum_reg} + {1'b0, sq_clip};
    assign sum_sat  = sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];

    always_ff @(posedge clk)
    begin
        if (pop_r)
        begin
            b_elem_reg    <= q_element;
            b_end_reg     <= vec_end;
            b_run_end_reg <= run_end;
            b_index_reg   <= ec_clamp;
        end
        c_sq_reg        <= mag * mag;
        c_end_reg       <= b_end_reg;
        c_run_end_reg   <= b_run_end_reg;
        c_index_reg     <= b_index_reg;
        ins_dist_reg    <= sum_sat;
        ins_index_reg   <= c_index_reg;
        ins_run_end_reg <= c_run_end_reg;
    end

endmodule

[rtl/core/ssdr_rank.sv]
// ----------------------------------------------------------------------------
// ssdr_rank
// sorted row of insertion cells and in-order result emission
// ----------------------------------------------------------------------------
module ssdr_rank
    import ssdr_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ssdr_ins_t         ins,
    output ssdr_status_t      status,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [IDX_W-1:0]  rank,
    output logic [IDX_W-1:0]  entry_index,
    output logic [DIST_W-1:0] distance,
    output logic              last
);

    logic [DIST_W-1:0]  dist_c [MAX_ENTRIES];
    logic [IDX_W-1:0]   idx_c  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] gt;

    logic               emitting_reg;
    logic [ECNT_W-1:0]  left_reg;
    logic [IDX_W-1:0]   rank_reg;
    logic               out_valid_reg;
    logic               load;
    logic               done;

    // cells past the fill level never compare
    always_comb
    begin
        for (int k = 0; k < MAX_ENTRIES; k++)
        begin
            gt[k] = (ECNT_W'(k) < {1'b0, ins.index}) && (dist_c[k] > ins.dist_val);
        end
    end

    assign load   = emitting_reg && (!out_valid_reg || out_ready);
    assign done   = load && (left_reg == ECNT_W'(1));
    assign status = '{emitting: emitting_reg, done: done};
    assign out_valid = out_valid_reg;

    // insert keeps equal distances ahead, emission shifts toward cell zero
    always_ff @(posedge clk)
    begin
        if (ins.valid)
        begin
            if (gt[0] || (ins.index == '0))
            begin
                dist_c[0] <= ins.dist_val;
                idx_c[0]  <= ins.index;
            end
            for (int k = 1; k < MAX_ENTRIES; k++)
            begin
                if (gt[k-1])
                begin
                    dist_c[k] <= dist_c[k-1];
                    idx_c[k]  <= idx_c[k-1];
                end
                else if (gt[k] || (ins.index == IDX_W'(k)))
                begin
                    dist_c[k] <= ins.dist_val;
                    idx_c[k]  <= ins.index;
                end
            end
        end
        else if (load)
        begin
            for (int k = 0; k < MAX_ENTRIES - 1; k++)
            begin
                dist_c[k] <= dist_c[k+1];
                idx_c[k]  <= idx_c[k+1];
            end
        end

        if (load)
        begin
            rank        <= rank_reg;
            entry_index <= idx_c[0];
            distance    <= dist_c[0];
            last        <= (left_reg == ECNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emitting_reg  <= 1'b0;
            left_reg      <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ins.valid && ins.run_end)
            begin
                emitting_reg <= 1'b1;
                left_reg     <= {1'b0, ins.index} + ECNT_W'(1);
                rank_reg     <= '0;
            end
            else if (load)
            begin
                left_reg <= left_reg - ECNT_W'(1);
                rank_reg <= rank_reg + IDX_W'(1);
                if (done)
                begin
                    emitting_reg <= 1'b0;
                end
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/core/ssd_nearest_neighbour_ranker.sv]
// a query item is written into the query store as it leaves the queue; a reference item passes stage b
// (query word read) and stage c (square) before it reaches its entry sum; the entry then enters the ranking row
// throughput: one item per cycle while no run is being ranked, set by the single-port query store and the accumulator
// a run end holds the queue until the last result is loaded into the output register, later under output stalls
// reset: asynchronous active low, clears positions, counters, sums and handshake state;
// query store and ranking row are not cleared
// ----------------------------------------------------------------------------
// ssd_nearest_neighbour_ranker
// brute force nearest neighbour search on sum of squared differences
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssd_nearest_neighbour_ranker
    import ssdr_pkg::*;
#(
    parameter int MAX_DIM      = DEF_MAX_DIM,
    parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
    parameter int ELEMENT_BITS = DEF_ELEMENT_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_ADDR_W-1:0]          cfg_addr,
    input  logic [CFG_W-1:0]               cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           opcode,
    input  logic signed [ELEMENT_BITS-1:0] element,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [IDX_W-1:0]               rank,
    output logic [IDX_W-1:0]               entry_index,
    output logic [DIST_W-1:0]              distance,
    output logic                           last
);

    // queue between front and accumulator
    logic                           q_valid;
    opcode_t                        q_opcode;
    logic signed [ELEMENT_BITS-1:0] q_element;
    logic                           q_pop;

    // finished entries and ranking status
    ssdr_ins_t                      ins;
    ssdr_status_t                   rk_status;
    logic                           acc_busy;

    // front: takes items and holds them in a four-deep queue
    ssdr_front #(
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .element   (element),
        .q_valid   (q_valid),
        .q_opcode  (q_opcode),
        .q_element (q_element),
        .q_pop     (q_pop)
    );

    // back, first half: query store, squares and sums, locked while a run is ranked
    ssdr_accum #(
        .MAX_DIM      (MAX_DIM),
        .MAX_ENTRIES  (MAX_ENTRIES),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_opcode  (q_opcode),
        .q_element (q_element),
        .q_pop     (q_pop),
        .status    (rk_status),
        .ins       (ins),
        .busy      (acc_busy)
    );

    // back, second half: sorted cells, results leave through an output register
    ssdr_rank #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_rank (
        .clk         (clk),
        .rst_n       (rst_n),
        .ins         (ins),
        .status      (rk_status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rank        (rank),
        .entry_index (entry_index),
        .distance    (distance),
        .last        (last)
    );

    // emission only happens inside a locked run
    `SSDR_ASSERT_IMPL(a_emit_in_run, rk_status.emitting, acc_busy, "emission outside a run")
    // no entry is inserted while the row is being shifted out
    `SSDR_ASSERT_IMPL(a_no_ins_emit, ins.valid, !rk_status.emitting, "insert during emission")
    // last result loaded releases both the row and the queue
    `SSDR_ASSERT_NEXT(a_done_release, rk_status.done, !rk_status.emitting && !acc_busy,
        "run not released after last result")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for ssd_nearest_neighbour_ranker
// loads query vectors and streams reference vectors through the item
// handshake, predicts each ranking run by hand or in a local model of the ranker and
// checks each result item field by field, under several idle and stall mixes
// ----------------------------------------------------------------------------
module testbench;
    import ssdr_pkg::*;

    localparam int MAX_DIM     = DEF_MAX_DIM;
    localparam int MAX_ENTRIES = DEF_MAX_ENTRIES;
    localparam int IDLE_LIMIT  = 4000;
    localparam int SETTLE      = 16;

    // one ranked entry as it leaves the block
    typedef struct packed {
        logic [IDX_W-1:0]  rank;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dist_val;
        logic              last;
    } ranked_t;

    // directed row: one item and, at a run end, the ranking read off by hand
    typedef struct {
        opcode_t            op;
        logic signed [15:0] el;
        int                 nres;
        ranked_t            r0;
        ranked_t            r1;
    } row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  opcode = 1'b0;
    logic signed [15:0]    element = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [IDX_W-1:0]      rank;
    logic [IDX_W-1:0]      entry_index;
    logic [DIST_W-1:0]     distance;
    logic                  last;

    ssd_nearest_neighbour_ranker i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .element     (element),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rank        (rank),
        .entry_index (entry_index),
        .distance    (distance),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // local model of the ranker
    // ------------------------------------------------------------------
    logic signed [15:0] query_mem [MAX_DIM];
    bit                 query_set [MAX_DIM];
    int                 query_pos;
    int                 elem_pos;
    int                 entry_ctr;
    logic [63:0]        entry_sum;
    logic [DIST_W-1:0]  row_dist [MAX_ENTRIES];
    logic [IDX_W-1:0]   row_idx  [MAX_ENTRIES];
    int                 vlen_reg = VLEN_RESET;
    int                 ecnt_reg = ECNT_RESET;

    ranked_t pending_ranks[$];

    int errors;
    int items_sent;
    int results_seen;
    int runs_done;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;

    function automatic int eff_len();
        if (vlen_reg == 0)
            return 1;
        return (vlen_reg > MAX_DIM) ? MAX_DIM : vlen_reg;
    endfunction

    function automatic int eff_cnt();
        if (ecnt_reg == 0)
            return 1;
        return (ecnt_reg > MAX_ENTRIES) ? MAX_ENTRIES : ecnt_reg;
    endfunction

    // append one expected result item
    task automatic expect_result(ranked_t r);
        pending_ranks.insert(pending_ranks.size(), r);
    endtask

    // advance the model by one accepted item; keep = queue the ranking it ends
    task automatic rank_item(opcode_t op, logic signed [15:0] el, bit keep);
        int          len;
        int          n;
        int          p;
        longint      diff;
        logic [63:0] total;
        ranked_t     r;
        len = eff_len();
        if (op == OP_QUERY)
        begin
            query_mem[query_pos] = el;
            query_set[query_pos] = 1'b1;
            query_pos = (query_pos + 1 >= len) ? 0 : query_pos + 1;
            return;
        end
        diff = longint'(el) - longint'(query_mem[elem_pos]);
        if (diff < 0)
            diff = -diff;
        total = entry_sum + 64'(diff * diff);
        entry_sum = (total > 64'(DIST_MAX)) ? 64'(DIST_MAX) : total;
        if (elem_pos + 1 < len)
        begin
            elem_pos++;
            return;
        end
        elem_pos = 0;
        if (entry_ctr >= MAX_ENTRIES)
            entry_ctr = MAX_ENTRIES - 1;
        // insertion keeps equal distances behind the earlier entry
        p = 0;
        while (p < entry_ctr && row_dist[p] <= entry_sum[DIST_W-1:0])
            p++;
        for (int k = entry_ctr; k > p; k--)
        begin
            row_dist[k] = row_dist[k-1];
            row_idx[k]  = row_idx[k-1];
        end
        row_dist[p] = entry_sum[DIST_W-1:0];
        row_idx[p]  = entry_ctr[IDX_W-1:0];
        entry_sum = '0;
        n = entry_ctr + 1;
        if (n < eff_cnt())
        begin
            entry_ctr = n;
            return;
        end
        entry_ctr = 0;
        runs_done++;
        if (keep)
            for (int k = 0; k < n; k++)
            begin
                r.rank     = k[IDX_W-1:0];
                r.idx      = row_idx[k];
                r.dist_val = row_dist[k];
                r.last     = (k + 1 == n);
                expect_result(r);
            end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------
    task automatic send_item(opcode_t op, logic signed [15:0] el, bit keep);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        element  <= el;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        rank_item(op, el, keep);
    endtask

    // registers only change once the block has drained
    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, int value);
        in_valid <= 1'b0;
        while (pending_ranks.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == REG_VECTOR_LENGTH)
            vlen_reg = value & 'h1fff;
        else
            ecnt_reg = value & 'h7f;
    endtask

    function automatic logic signed [15:0] pick_element();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // fill every query position of the current length, wrap included
    task automatic load_query();
        repeat (eff_len() + 1) send_item(OP_QUERY, pick_element(), 1'b1);
    endtask

    // mostly reference streams, with stray query writes as noise;
    // a reference item goes out only where its query element is written
    task automatic random_items(int count, int ref_pct);
        for (int i = 0; i < count; i++)
        begin
            if (query_set[elem_pos] && $urandom_range(0, 99) < ref_pct)
                send_item(OP_REF, pick_element(), 1'b1);
            else
                send_item(OP_QUERY, pick_element(), 1'b1);
        end
    endtask

    task automatic set_mix(int sender_idle, int receiver_stall);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        ranked_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_ranks.size() == 0)
            begin
                report_mismatch("unexpected item, entry_index", entry_index, -1);
            end
            else
            begin
                want = pending_ranks.pop_front();
                if (rank !== want.rank)
                    report_mismatch("rank", rank, want.rank);
                if (entry_index !== want.idx)
                    report_mismatch("entry_index", entry_index, want.idx);
                if (distance !== want.dist_val)
                    report_mismatch("distance", distance, want.dist_val);
                if (last !== want.last)
                    report_mismatch("last", last, want.last);
            end
        end
    end

    // watchdog: too long without any item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    row_t rows[15];

    initial
    begin
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        runs_done = 0;
        quiet_cycles = 0;
        query_pos = 0;
        elem_pos = 0;
        entry_ctr = 0;
        entry_sum = '0;
        set_mix(0, 0);

        // single element vectors, two entries per run
        rows[0]  = '{OP_QUERY, 16'sh7fff, 0, '0, '0};
        rows[1]  = '{OP_REF,   16'sh8000, 0, '0, '0};
        rows[2]  = '{OP_REF,   16'sh7fff, 2, '{6'd0, 6'd1, 44'd0, 1'b0},
                                             '{6'd1, 6'd0, 44'd4294836225, 1'b1}};
        rows[3]  = '{OP_QUERY, 16'sh8000, 0, '0, '0};
        rows[4]  = '{OP_REF,   16'sh7fff, 0, '0, '0};
        rows[5]  = '{OP_REF,   16'sh8000, 2, '{6'd0, 6'd1, 44'd0, 1'b0},
                                             '{6'd1, 6'd0, 44'd4294836225, 1'b1}};
        // equal distances: lower index ranks first
        rows[6]  = '{OP_QUERY, 16'sd0,    0, '0, '0};
        rows[7]  = '{OP_REF,   16'sd5,    0, '0, '0};
        rows[8]  = '{OP_REF,  -16'sd5,    2, '{6'd0, 6'd0, 44'd25, 1'b0},
                                             '{6'd1, 6'd1, 44'd25, 1'b1}};
        rows[9]  = '{OP_QUERY, 16'sd0,    0, '0, '0};
        rows[10] = '{OP_REF,   16'sd0,    0, '0, '0};
        rows[11] = '{OP_REF,   16'sd0,    2, '{6'd0, 6'd0, 44'd0, 1'b0},
                                             '{6'd1, 6'd1, 44'd0, 1'b1}};
        rows[12] = '{OP_QUERY, -16'sd1,   0, '0, '0};
        rows[13] = '{OP_REF,   16'sd1,    0, '0, '0};
        rows[14] = '{OP_REF,  -16'sd1,    2, '{6'd0, 6'd1, 44'd0, 1'b0},
                                             '{6'd1, 6'd0, 44'd4, 1'b1}};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_VECTOR_LENGTH, 1);
        write_reg(REG_ENTRY_COUNT, 2);
        foreach (rows[i])
        begin
            // typed rankings replace the model's own for these rows
            send_item(rows[i].op, rows[i].el, rows[i].nres == 0);
            if (rows[i].nres > 0)
            begin
                expect_result(rows[i].r0);
                expect_result(rows[i].r1);
            end
        end

        // length 0 acts as 1, count above the row acts as full
        write_reg(REG_VECTOR_LENGTH, 0);
        write_reg(REG_ENTRY_COUNT, 127);
        load_query();
        random_items(80, 95);

        // longer vector, count 0 acts as 1 and meets an entry counter beyond it
        set_mix(0, 61);
        write_reg(REG_VECTOR_LENGTH, 24);
        write_reg(REG_ENTRY_COUNT, 0);
        load_query();
        repeat (24) send_item(OP_REF, pick_element(), 1'b1);

        // random phases, each with its own idle and stall mix; a phase may stop
        // mid-vector so that the next setting meets a stream in progress
        set_mix(0, 0);
        write_reg(REG_VECTOR_LENGTH, 3);
        write_reg(REG_ENTRY_COUNT, 4);
        load_query();
        random_items(30, 85);

        set_mix(61, 0);
        write_reg(REG_VECTOR_LENGTH, 2);
        write_reg(REG_ENTRY_COUNT, 8);
        load_query();
        random_items(30, 85);

        set_mix(0, 61);
        write_reg(REG_VECTOR_LENGTH, 5);
        write_reg(REG_ENTRY_COUNT, 3);
        load_query();
        random_items(30, 85);

        set_mix(36, 36);
        write_reg(REG_VECTOR_LENGTH, 1);
        write_reg(REG_ENTRY_COUNT, 16);
        load_query();
        random_items(40, 90);

        // drain
        in_valid <= 1'b0;
        while (pending_ranks.size() != 0)
            @(posedge clk);
        repeat (SETTLE * 4) @(posedge clk);

        $display("%0d items sent, %0d ranking runs, %0d result items checked",
                 items_sent, runs_done, results_seen);
        $display("vector lengths 0 to 24 and entry counts 0 to 127 under idle and stall mixes");
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
